// ===== rtl/core/sefr_pkg.sv =====
// Shared types and constants for the STX/ETX frame receiver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sefr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STATION_ID = 2'd2;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h02;
	localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h03;
	localparam logic [BYTE_W-1:0] STATION_ID_RST = 8'h00;

	// Request commands
	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HEADER   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd5;

	// Accepted command letters
	localparam logic [BYTE_W-1:0] LETTER_S = 8'h53;
	localparam logic [BYTE_W-1:0] LETTER_T = 8'h54;
	localparam logic [BYTE_W-1:0] LETTER_M = 8'h4D;
	localparam logic [BYTE_W-1:0] LETTER_O = 8'h4F;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] end_byte;
		logic [BYTE_W-1:0] station_id;
	} cfg_t;

	typedef struct packed {
		logic              cmd;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   payload_byte;
		logic [BYTE_W-1:0]   payload_index;
		logic [BYTE_W-1:0]   frame_command;
		logic [BYTE_W-1:0]   frame_length;
		logic [BYTE_W-1:0]   check_computed;
		logic [BYTE_W-1:0]   check_received;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/sefr_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Depends on sefr_pkg for the default payload type.
`timescale 1ns / 1ps
`default_nettype none

interface sefr_stream_if
	import sefr_pkg::*;
	#(parameter type payload_t = in_item_t);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/sefr_cfg_regs.sv =====
// Configuration registers of the frame receiver: start, end and station bytes.
// Depends on sefr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sefr_cfg_regs
	import sefr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	output      cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.end_byte   <= END_BYTE_RST;
			cfg_q.station_id <= STATION_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_BYTE: cfg_q.start_byte <= cfg_data;
				CFG_END_BYTE:   cfg_q.end_byte   <= cfg_data;
				CFG_STATION_ID: cfg_q.station_id <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/sefr_parser.sv =====
// Frame parser: phase and frame state registers plus the per-request update.
// Depends on sefr_pkg. The result is combinational from the current request.
`timescale 1ns / 1ps
`default_nettype none

module sefr_parser
	import sefr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      advance,
	input  wire in_item_t  item,
	output      out_item_t result
);

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_ID    = 3'd1;
	localparam logic [2:0] PH_LEN   = 3'd2;
	localparam logic [2:0] PH_CMD   = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_CHECK = 3'd5;
	localparam logic [2:0] PH_END   = 3'd6;

	logic [2:0]        phase_q,  phase_d;
	logic              held_q,   held_d;
	logic [BYTE_W-1:0] len_q,    len_d;
	logic [BYTE_W-1:0] cnt_q,    cnt_d;
	logic [BYTE_W-1:0] letter_q, letter_d;
	logic [BYTE_W-1:0] chk_q,    chk_d;
	logic [BYTE_W-1:0] cap_q,    cap_d;

	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   pbyte;
	logic [BYTE_W-1:0]   pidx;
	logic                err;
	logic                letter_ok;
	logic [BYTE_W-1:0]   b;

	assign b = item.rx_byte;
	assign letter_ok = (b == LETTER_S) || (b == LETTER_T) ||
	                   (b == LETTER_M) || (b == LETTER_O);

	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		letter_d = letter_q;
		chk_d    = chk_q;
		cap_d    = cap_q;
		status   = ST_HEADER;
		pbyte    = '0;
		pidx     = '0;
		err      = 1'b0;

		if (item.cmd == CMD_RELEASE) begin
			phase_d  = PH_START;
			held_d   = 1'b0;
			len_d    = '0;
			cnt_d    = '0;
			letter_d = '0;
			chk_d    = '0;
			cap_d    = '0;
			status   = ST_IDLE;
		end else if (held_q) begin
			status = ST_BUSY;
		end else begin
			unique case (phase_q)
				PH_ID: begin
					if (b == cfg.station_id) phase_d = PH_LEN;
					else                     err = 1'b1;
				end
				PH_LEN: begin
					len_d   = b;
					cnt_d   = '0;
					chk_d   = '0;
					phase_d = PH_CMD;
				end
				PH_CMD: begin
					if (letter_ok) begin
						letter_d = b;
						chk_d    = chk_q ^ b;
						phase_d  = (len_q == '0) ? PH_CHECK : PH_DATA;
					end else begin
						err = 1'b1;
					end
				end
				PH_DATA: begin
					status  = ST_PAYLOAD;
					pbyte   = b;
					pidx    = cnt_q;
					chk_d   = chk_q ^ b;
					cnt_d   = cnt_q + 8'd1;
					if (cnt_d >= len_q) phase_d = PH_CHECK;
				end
				PH_CHECK: begin
					cap_d   = b;
					phase_d = PH_END;
				end
				PH_END: begin
					if (b == cfg.end_byte) begin
						held_d  = 1'b1;
						phase_d = PH_START;
						status  = ST_COMPLETE;
					end else begin
						err = 1'b1;
					end
				end
				default: begin
					// waiting for start, also the unused phase code
					if (b == cfg.start_byte) phase_d = PH_ID;
					else                     err = 1'b1;
				end
			endcase

			if (err) begin
				phase_d  = PH_START;
				held_d   = 1'b0;
				len_d    = '0;
				cnt_d    = '0;
				letter_d = '0;
				chk_d    = '0;
				cap_d    = '0;
				status   = ST_ERROR;
				pbyte    = '0;
				pidx     = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			held_q   <= 1'b0;
			len_q    <= '0;
			cnt_q    <= '0;
			letter_q <= '0;
			chk_q    <= '0;
			cap_q    <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			held_q   <= held_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			letter_q <= letter_d;
			chk_q    <= chk_d;
			cap_q    <= cap_d;
		end
	end

	assign result.status         = status;
	assign result.payload_byte   = pbyte;
	assign result.payload_index  = pidx;
	assign result.frame_command  = letter_d;
	assign result.frame_length   = len_d;
	assign result.check_computed = chk_d;
	assign result.check_received = cap_d;

endmodule

`default_nettype wire

// ===== rtl/core/stx_etx_frame_receiver_unit.sv =====
// STX/ETX frame receiver, top level: input register, parser, result register.
// Throughput: one request per cycle while the result side takes its results;
// the parser state update is a single byte-wide step.
// Reset (arst_n low, asynchronous): parser waits for start, no frame held, both stages
// empty, registers return to start 0x02, end 0x03, station 0x00.
`timescale 1ns / 1ps
`default_nettype none

module stx_etx_frame_receiver_unit
	import sefr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	sefr_stream_if.sink               rx,
	sefr_stream_if.source             res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t item_s2;
	logic      valid_s2;
	logic      advance;

	// Configuration registers; the user writes them only while the block is idle (not enforced).
	sefr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the request in stage 1 into the result register whenever that
	// register is empty or its result is being taken this cycle.
	assign advance  = valid_s1 && (!valid_s2 || res.ready);
	// Take a new request whenever stage 1 is empty or moving on, so a request
	// still lands while a finished result waits downstream.
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register: hold while stalled, load on accept.
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.payload;
		end
	end

	// Parser state commits only when the request advances, so each request
	// updates the frame state exactly once.
	sefr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: hold until taken.
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= result;
		end
	end

	assign res.valid   = valid_s2;
	assign res.payload = item_s2;

endmodule

`default_nettype wire

// ===== tb/sv/stx_etx_frame_receiver_unit_tb.sv =====
// Self-checking bench for the STX/ETX frame receiver top level.
// Uses sefr_pkg and sefr_stream_if from the RTL; drives requests and checks every
// result against a cycle-free frame parser in the bench or a hand-typed expected result.
`timescale 1ns / 1ps

module stx_etx_frame_receiver_unit_tb;
	import sefr_pkg::*;

	// Parser phases of the bench's own frame tracker
	typedef enum logic [2:0] {
		AWAIT_START = 3'd0,
		AWAIT_ID    = 3'd1,
		AWAIT_LEN   = 3'd2,
		AWAIT_CMD   = 3'd3,
		IN_PAYLOAD  = 3'd4,
		AWAIT_CHECK = 3'd5,
		AWAIT_END   = 3'd6
	} frame_phase_e;

	// One request to send; "fixed" rows carry a hand-typed expected result
	typedef struct {
		in_item_t  req;
		bit        fixed;
		out_item_t want;
	} stim_row_t;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 4;   // the pipeline is 2 stages deep
	localparam int unsigned REPORT_MAX     = 10;
	localparam int unsigned PHASE_ITEMS    = 235;
	localparam int unsigned RANDOM_PHASES  = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;

	sefr_stream_if #(.payload_t(in_item_t))  rx_if ();
	sefr_stream_if #(.payload_t(out_item_t)) res_if ();

	stx_etx_frame_receiver_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Bench copy of the configuration registers
	logic [BYTE_W-1:0] open_byte  = START_BYTE_RST;
	logic [BYTE_W-1:0] close_byte = END_BYTE_RST;
	logic [BYTE_W-1:0] own_id     = STATION_ID_RST;

	// Bench copy of the parser state
	frame_phase_e      phase      = AWAIT_START;
	bit                held       = 1'b0;
	logic [BYTE_W-1:0] decl_len   = '0;
	logic [BYTE_W-1:0] pay_cnt    = '0;
	logic [BYTE_W-1:0] cmd_letter = '0;
	logic [BYTE_W-1:0] xor_check  = '0;
	logic [BYTE_W-1:0] bcc_byte   = '0;

	logic [BYTE_W-1:0] letters [4] = '{LETTER_S, LETTER_T, LETTER_M, LETTER_O};

	out_item_t   frame_results [$];   // results still owed by the block, oldest first
	stim_row_t   stim [$];            // requests waiting to be sent
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles    = 0;
	int unsigned burst_left     = 0;
	int unsigned stall_cyc      = 0;
	int unsigned stall_mode     = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Drop the frame tracker back to waiting for a start byte; registers stay
	function automatic void clear_parser();
		phase      = AWAIT_START;
		held       = 1'b0;
		decl_len   = '0;
		pay_cnt    = '0;
		cmd_letter = '0;
		xor_check  = '0;
		bcc_byte   = '0;
	endfunction

	// Advance the frame tracker by one request and return the result it causes
	function automatic out_item_t parse_request(in_item_t req);
		out_item_t r;
		bit        bad;
		r        = '0;
		r.status = ST_HEADER;
		bad      = 1'b0;
		if (req.cmd == CMD_RELEASE) begin
			clear_parser();
			r.status = ST_IDLE;
		end else if (held) begin
			// Refuse bytes while a completed frame is waiting; state holds
			r.status = ST_BUSY;
		end else begin
			case (phase)
				AWAIT_ID: begin
					if (req.rx_byte == own_id) phase = AWAIT_LEN;
					else bad = 1'b1;
				end
				AWAIT_LEN: begin
					decl_len  = req.rx_byte;
					pay_cnt   = '0;
					xor_check = '0;
					phase     = AWAIT_CMD;
				end
				AWAIT_CMD: begin
					if (req.rx_byte == LETTER_S || req.rx_byte == LETTER_T ||
					    req.rx_byte == LETTER_M || req.rx_byte == LETTER_O) begin
						cmd_letter = req.rx_byte;
						xor_check  = xor_check ^ req.rx_byte;
						// An empty payload skips straight to the check byte
						phase      = (decl_len == '0) ? AWAIT_CHECK : IN_PAYLOAD;
					end else begin
						bad = 1'b1;
					end
				end
				IN_PAYLOAD: begin
					r.status        = ST_PAYLOAD;
					r.payload_byte  = req.rx_byte;
					r.payload_index = pay_cnt;
					xor_check       = xor_check ^ req.rx_byte;
					pay_cnt         = pay_cnt + 8'd1;
					if (pay_cnt >= decl_len) phase = AWAIT_CHECK;
				end
				AWAIT_CHECK: begin
					// Capture only; the consumer compares the two checks
					bcc_byte = req.rx_byte;
					phase    = AWAIT_END;
				end
				AWAIT_END: begin
					if (req.rx_byte == close_byte) begin
						held     = 1'b1;
						phase    = AWAIT_START;
						r.status = ST_COMPLETE;
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					// Waiting for start, and any unused phase code
					if (req.rx_byte == open_byte) phase = AWAIT_ID;
					else bad = 1'b1;
				end
			endcase
			if (bad) begin
				clear_parser();
				r.status = ST_ERROR;
			end
		end
		r.frame_command  = cmd_letter;
		r.frame_length   = decl_len;
		r.check_computed = xor_check;
		r.check_received = bcc_byte;
		return r;
	endfunction

	// Result with the given status and every other field zero
	function automatic out_item_t blank_result(logic [STATUS_W-1:0] st);
		out_item_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	function automatic void add_row(logic c, logic [BYTE_W-1:0] b, bit fixed, out_item_t want);
		stim_row_t row;
		row.req.cmd     = c;
		row.req.rx_byte = b;
		row.fixed       = fixed;
		row.want        = want;
		stim.push_back(row);
	endfunction

	// Queue mostly well-formed frames for the current registers, with broken
	// frames, stray bytes, mid-frame releases and busy bytes mixed in
	task automatic add_traffic(int unsigned count, bit with_long);
		logic [BYTE_W-1:0] frame [$];
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] letter;
		logic [BYTE_W-1:0] chk;
		logic [BYTE_W-1:0] b;
		int unsigned       pos;
		int unsigned       first;
		bit                long_done;
		first     = stim.size();
		long_done = !with_long;
		while (stim.size() < first + count) begin
			if ($urandom_range(0, 99) < 8) begin
				// Stray request outside any frame
				if ($urandom_range(0, 2) == 0) add_row(CMD_RELEASE, 8'($urandom), 1'b0, '0);
				else add_row(CMD_BYTE, 8'($urandom), 1'b0, '0);
			end else begin
				if (!long_done) begin
					len       = 8'hFF;
					long_done = 1'b1;
				end else if ($urandom_range(0, 29) == 0) begin
					len = 8'($urandom_range(9, 255));
				end else begin
					len = 8'($urandom_range(0, 8));
				end
				letter = letters[$urandom_range(0, 3)];
				frame.delete();
				frame.push_back(open_byte);
				frame.push_back(own_id);
				frame.push_back(len);
				frame.push_back(letter);
				chk = letter;
				for (int i = 0; i < int'(len); i++) begin
					b   = 8'($urandom);
					chk = chk ^ b;
					frame.push_back(b);
				end
				// Leave some checks wrong; the block only captures them
				if ($urandom_range(0, 3) == 0) chk = 8'($urandom);
				frame.push_back(chk);
				frame.push_back(close_byte);
				// Corrupt one byte of some frames
				if ($urandom_range(0, 5) == 0) begin
					pos        = $urandom_range(0, frame.size() - 1);
					frame[pos] = 8'($urandom);
				end
				foreach (frame[k]) begin
					if ($urandom_range(0, 199) == 0) add_row(CMD_RELEASE, 8'($urandom), 1'b0, '0);
					add_row(CMD_BYTE, frame[k], 1'b0, '0);
				end
				repeat ($urandom_range(0, 2)) add_row(CMD_BYTE, 8'($urandom), 1'b0, '0);
				if ($urandom_range(0, 9) != 0) add_row(CMD_RELEASE, 8'($urandom), 1'b0, '0);
			end
		end
	endtask

	// Send every queued request in bursts with random gaps; predict at acceptance
	task automatic drive_rows();
		stim_row_t   row;
		out_item_t   pred;
		int unsigned gap;
		while (stim.size() != 0) begin
			row = stim.pop_front();
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap != 0) begin
					rx_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
			rx_if.valid   <= 1'b1;
			rx_if.payload <= row.req;
			do @(posedge clk); while (rx_if.ready !== 1'b1);
			pred = parse_request(row.req);
			frame_results.push_back(row.fixed ? row.want : pred);
		end
		rx_if.valid <= 1'b0;
	endtask

	// Hold until every owed result is in, then let the pipeline settle
	task automatic wait_idle();
		while (frame_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three registers one after another, keeping the bench copy in step
	task automatic program_regs(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] e,
	                            logic [BYTE_W-1:0] id);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_BYTE;
		cfg_data  <= s;
		@(posedge clk);
		open_byte = s;
		cfg_index <= CFG_END_BYTE;
		cfg_data  <= e;
		@(posedge clk);
		close_byte = e;
		cfg_index <= CFG_STATION_ID;
		cfg_data  <= id;
		@(posedge clk);
		own_id = id;
		cfg_we <= 1'b0;
	endtask

	// Main sequence: reset, directed table, then random phases under changing registers
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_if.valid   = 1'b0;
		rx_if.payload = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table under reset registers: start 02, end 03, station 00
		// Wrong byte while waiting for start, then a release on an idle parser
		add_row(CMD_BYTE,    8'h00, 1'b1, blank_result(ST_ERROR));
		add_row(CMD_BYTE,    8'hFF, 1'b1, blank_result(ST_ERROR));
		add_row(CMD_RELEASE, 8'hFF, 1'b1, blank_result(ST_IDLE));
		// Full frame with extreme payload bytes and a wrong check byte
		add_row(CMD_BYTE, START_BYTE_RST, 1'b0, '0);
		add_row(CMD_BYTE, STATION_ID_RST, 1'b0, '0);
		add_row(CMD_BYTE, 8'h02,          1'b0, '0);
		add_row(CMD_BYTE, LETTER_S,       1'b0, '0);
		add_row(CMD_BYTE, 8'h00,          1'b0, '0);
		add_row(CMD_BYTE, 8'hFF,          1'b0, '0);
		add_row(CMD_BYTE, 8'h5A,          1'b0, '0);
		add_row(CMD_BYTE, END_BYTE_RST,   1'b0, '0);
		// Byte while the frame is held, then release
		add_row(CMD_BYTE,    8'hFF, 1'b0, '0);
		add_row(CMD_RELEASE, 8'h00, 1'b1, blank_result(ST_IDLE));
		// Zero-length frame goes straight from command to check byte
		add_row(CMD_BYTE, START_BYTE_RST, 1'b0, '0);
		add_row(CMD_BYTE, STATION_ID_RST, 1'b0, '0);
		add_row(CMD_BYTE, 8'h00,          1'b0, '0);
		add_row(CMD_BYTE, LETTER_O,       1'b0, '0);
		add_row(CMD_BYTE, LETTER_O,       1'b0, '0);
		add_row(CMD_BYTE, END_BYTE_RST,   1'b0, '0);
		add_row(CMD_RELEASE, 8'h00, 1'b1, blank_result(ST_IDLE));
		// Wrong station id
		add_row(CMD_BYTE, START_BYTE_RST, 1'b0, '0);
		add_row(CMD_BYTE, 8'h07,          1'b1, blank_result(ST_ERROR));
		// Bad command letter
		add_row(CMD_BYTE, START_BYTE_RST, 1'b0, '0);
		add_row(CMD_BYTE, STATION_ID_RST, 1'b0, '0);
		add_row(CMD_BYTE, 8'h01,          1'b0, '0);
		add_row(CMD_BYTE, 8'h58,          1'b1, blank_result(ST_ERROR));
		drive_rows();

		for (int p = 1; p <= int'(RANDOM_PHASES); p++) begin
			wait_idle();
			case (p)
				1:       program_regs(8'h00, 8'hFF, 8'hFF);
				2:       program_regs(8'hFF, 8'h00, 8'h00);
				3:       program_regs(START_BYTE_RST, END_BYTE_RST, STATION_ID_RST);
				6:       program_regs(LETTER_S, LETTER_S, LETTER_M);
				8:       program_regs(8'hFF, 8'hFF, 8'hFF);
				default: program_regs(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			// Phase 4 always carries a frame of the largest length
			add_traffic(PHASE_ITEMS, p == 4);
			drive_rows();
		end

		wait_idle();
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Result side: stall on a pattern that switches among four modes, picked at random
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0:       res_if.ready <= 1'b1;
				1:       res_if.ready <= ($urandom_range(0, 3) != 0);
				2:       res_if.ready <= (stall_cyc % 7 < 4);
				default: res_if.ready <= (stall_cyc % 23 < 3);
			endcase
			stall_cyc++;
		end
	end

	// Compare each accepted result with the oldest owed one
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (frame_results.size() == 0) begin
				if (mismatch_count < REPORT_MAX)
					$display("unexpected result: status %0d byte %02h index %02h",
					         res_if.payload.status, res_if.payload.payload_byte,
					         res_if.payload.payload_index);
				mismatch_count++;
			end else begin
				want = frame_results.pop_front();
				if (res_if.payload.status         !== want.status         ||
				    res_if.payload.payload_byte   !== want.payload_byte   ||
				    res_if.payload.payload_index  !== want.payload_index  ||
				    res_if.payload.frame_command  !== want.frame_command  ||
				    res_if.payload.frame_length   !== want.frame_length   ||
				    res_if.payload.check_computed !== want.check_computed ||
				    res_if.payload.check_received !== want.check_received) begin
					if (mismatch_count < REPORT_MAX) begin
						$display("mismatch: status exp %0d got %0d, byte exp %02h got %02h",
						         want.status, res_if.payload.status,
						         want.payload_byte, res_if.payload.payload_byte);
						$display("  index exp %02h got %02h, cmd exp %02h got %02h",
						         want.payload_index, res_if.payload.payload_index,
						         want.frame_command, res_if.payload.frame_command);
						$display("  len exp %02h got %02h, xor exp %02h got %02h, bcc exp %02h got %02h",
						         want.frame_length, res_if.payload.frame_length,
						         want.check_computed, res_if.payload.check_computed,
						         want.check_received, res_if.payload.check_received);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run if neither side moves a request for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
			    (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

// ===== filelist.f =====
rtl/core/sefr_pkg.sv
rtl/core/sefr_stream_if.sv
rtl/core/sefr_cfg_regs.sv
rtl/core/sefr_parser.sv
rtl/core/stx_etx_frame_receiver_unit.sv
tb/sv/stx_etx_frame_receiver_unit_tb.sv
